FILE: hw/rtl/idxheap_pkg.sv
// Shared types and codes of the indexed min-heap queue.
// Used by the controller, the datapath and the top level; no dependencies.
package idxheap_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int KEY_WIDTH  = 32;

    localparam int CMD_W = 2;
    localparam int ID_W  = 10;
    localparam int PRI_W = 32;
    localparam int STS_W = 2;
    localparam int OCC_W = 11;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEC  = 2'd2;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY     = 2'd1;
    localparam logic [STS_W-1:0] STS_PUSH_FAIL = 2'd2;
    localparam logic [STS_W-1:0] STS_NOT_QUEUED = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_ERR,
        OP_PUSH_START,
        OP_POP_START,
        OP_DEC_RD,
        OP_DEC_START,
        OP_UP_RD,
        OP_UP_MOVE,
        OP_DN_RD,
        OP_DN_MOVE,
        OP_PLACE,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             push_ok;
        logic             nonempty;
        logic             last_one;
        logic             dec_ok;
        logic             dec_lower;
        logic             slot_zero;
        logic             up_go;
        logic             dn_go;
        logic             clr_last;
    } t_dp_status;

endpackage

FILE: hw/rtl/idxheap_datapath.sv
// Datapath of the indexed min-heap queue: heap, position and membership
// memories, the moving entry, the sift compares and the result registers.
// Depends on idxheap_pkg.
module idxheap_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  idxheap_pkg::t_dp_op           i_op,
    output idxheap_pkg::t_dp_status       o_status_flags,
    input  logic [idxheap_pkg::CMD_W-1:0] i_command,
    input  logic [idxheap_pkg::ID_W-1:0]  i_node_id,
    input  logic [idxheap_pkg::PRI_W-1:0] i_priority_req,
    output logic [idxheap_pkg::ID_W-1:0]  o_popped_node,
    output logic [idxheap_pkg::PRI_W-1:0] o_popped_priority,
    output logic [idxheap_pkg::STS_W-1:0] o_status,
    output logic [idxheap_pkg::OCC_W-1:0] o_occupancy
);
    import idxheap_pkg::*;

    localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int EW = IW + KEY_WIDTH;
    localparam int AW = IW + 2;

    logic [EW-1:0] heap_mem [NODE_COUNT];
    logic [IW-1:0] pos_mem  [NODE_COUNT];
    logic          qf_mem   [NODE_COUNT];

    logic [CMD_W-1:0]     r_cmd;
    logic [ID_W-1:0]      r_id;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_clr;
    logic [IW-1:0]        r_slot;
    logic [IW-1:0]        r_cur_node;
    logic [KEY_WIDTH-1:0] r_cur_key;
    logic                 r_eq;
    logic [EW-1:0]        r_rd_a;
    logic [EW-1:0]        r_rd_b;
    logic [IW-1:0]        r_pos_rd;
    logic                 r_qf_rd;
    logic [ID_W-1:0]      r_res_node;
    logic [PRI_W-1:0]     r_res_key;
    logic [STS_W-1:0]     r_res_status;

    logic [IW-1:0]        id_ix;
    logic [IW-1:0]        in_ix;
    logic                 id_ok;
    logic [IW-1:0]        a_node;
    logic [KEY_WIDTH-1:0] a_key;
    logic [IW-1:0]        b_node;
    logic [KEY_WIDTH-1:0] b_key;
    logic [IW-1:0]        parent;
    logic [AW-1:0]        c1;
    logic [AW-1:0]        c2;
    logic [AW-1:0]        n_ext;
    logic                 b1;
    logic                 b2;
    logic [KEY_WIDTH-1:0] bk;
    logic                 dn_go;
    logic                 pick2;
    logic                 up_go;
    logic [STS_W-1:0]     err_code;

    logic                 heap_rd;
    logic [IW-1:0]        heap_ra;
    logic [IW-1:0]        heap_rb;
    logic                 heap_we;
    logic [IW-1:0]        heap_wa;
    logic [EW-1:0]        heap_wd;
    logic                 pos_we;
    logic [IW-1:0]        pos_wa;
    logic                 qf_we;
    logic [IW-1:0]        qf_wa;
    logic                 qf_wd;

    assign id_ix  = IW'(r_id);
    assign in_ix  = IW'(i_node_id);
    assign id_ok  = (32'(r_id) < NODE_COUNT);
    assign a_node = r_rd_a[EW-1:KEY_WIDTH];
    assign a_key  = r_rd_a[KEY_WIDTH-1:0];
    assign b_node = r_rd_b[EW-1:KEY_WIDTH];
    assign b_key  = r_rd_b[KEY_WIDTH-1:0];
    assign parent = IW'((r_slot - IW'(1)) >> 1);
    assign c1     = {1'b0, r_slot, 1'b1};
    assign c2     = {1'b0, r_slot, 1'b0} + AW'(2);
    assign n_ext  = AW'(r_count);

    always_comb begin
        up_go = r_eq ? (a_key >= r_cur_key) : (a_key > r_cur_key);
        b1    = (r_cur_key >= a_key);
        bk    = b1 ? a_key : r_cur_key;
        b2    = (bk >= b_key);
        if (c2 < n_ext) begin
            dn_go = b1 || b2;
            pick2 = b2;
        end else if (c1 < n_ext) begin
            dn_go = b1;
            pick2 = 1'b0;
        end else begin
            dn_go = 1'b0;
            pick2 = 1'b0;
        end
        case (r_cmd)
            CMD_PUSH: err_code = STS_PUSH_FAIL;
            CMD_POP:  err_code = STS_EMPTY;
            CMD_DEC:  err_code = STS_NOT_QUEUED;
            default:  err_code = STS_OK;
        endcase
    end

    always_comb begin
        o_status_flags.cmd       = r_cmd;
        o_status_flags.push_ok   = id_ok && !r_qf_rd && (r_count != CW'(NODE_COUNT));
        o_status_flags.nonempty  = (r_count != '0);
        o_status_flags.last_one  = (r_count == CW'(1));
        o_status_flags.dec_ok    = id_ok && r_qf_rd;
        o_status_flags.dec_lower = (r_key < a_key);
        o_status_flags.slot_zero = (r_slot == '0);
        o_status_flags.up_go     = up_go;
        o_status_flags.dn_go     = dn_go;
        o_status_flags.clr_last  = (r_clr == IW'(NODE_COUNT - 1));
    end

    always_comb begin
        heap_rd = 1'b0;
        heap_ra = '0;
        heap_rb = IW'(r_count - CW'(1));
        heap_we = 1'b0;
        heap_wa = r_slot;
        heap_wd = {r_cur_node, r_cur_key};
        pos_we  = 1'b0;
        pos_wa  = r_cur_node;
        qf_we   = 1'b0;
        qf_wa   = id_ix;
        qf_wd   = 1'b0;
        unique case (i_op)
            OP_CLEAR: begin
                qf_we = 1'b1;
                qf_wa = r_clr;
            end
            OP_ACCEPT: heap_rd = 1'b1;
            OP_PUSH_START: begin
                qf_we = 1'b1;
                qf_wd = 1'b1;
            end
            OP_POP_START: begin
                qf_we = 1'b1;
                qf_wa = a_node;
            end
            OP_DEC_RD: begin
                heap_rd = 1'b1;
                heap_ra = r_pos_rd;
            end
            OP_UP_RD: begin
                heap_rd = 1'b1;
                heap_ra = parent;
            end
            OP_UP_MOVE: begin
                heap_we = 1'b1;
                heap_wd = r_rd_a;
                pos_we  = 1'b1;
                pos_wa  = a_node;
            end
            OP_DN_RD: begin
                heap_rd = 1'b1;
                heap_ra = IW'(c1);
                heap_rb = IW'(c2);
            end
            OP_DN_MOVE: begin
                heap_we = 1'b1;
                heap_wd = pick2 ? r_rd_b : r_rd_a;
                pos_we  = 1'b1;
                pos_wa  = pick2 ? b_node : a_node;
            end
            OP_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (heap_rd) begin
            r_rd_a <= heap_mem[heap_ra];
            r_rd_b <= heap_mem[heap_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= r_slot;
        end
        if (i_op == OP_ACCEPT) begin
            r_pos_rd <= pos_mem[in_ix];
        end
    end

    always_ff @(posedge i_clk) begin
        if (qf_we) begin
            qf_mem[qf_wa] <= qf_wd;
        end
        if (i_op == OP_ACCEPT) begin
            r_qf_rd <= qf_mem[in_ix];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            if (i_op == OP_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_op == OP_PUSH_START) begin
                r_count <= r_count + CW'(1);
            end else if (i_op == OP_POP_START) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_ACCEPT: begin
                r_cmd        <= i_command;
                r_id         <= i_node_id;
                r_key        <= KEY_WIDTH'(i_priority_req);
                r_res_node   <= '0;
                r_res_key    <= '0;
                r_res_status <= STS_OK;
            end
            OP_ERR: r_res_status <= err_code;
            OP_PUSH_START: begin
                r_cur_node <= id_ix;
                r_cur_key  <= r_key;
                r_slot     <= IW'(r_count);
                r_eq       <= 1'b1;
            end
            OP_POP_START: begin
                r_res_node <= ID_W'(a_node);
                r_res_key  <= PRI_W'(a_key);
                r_cur_node <= b_node;
                r_cur_key  <= b_key;
                r_slot     <= '0;
            end
            OP_DEC_START: begin
                r_cur_node <= id_ix;
                r_cur_key  <= r_key;
                r_slot     <= r_pos_rd;
                r_eq       <= 1'b0;
            end
            OP_UP_MOVE: r_slot <= parent;
            OP_DN_MOVE: r_slot <= pick2 ? IW'(c2) : IW'(c1);
            OP_OUT: begin
                o_popped_node     <= r_res_node;
                o_popped_priority <= r_res_key;
                o_status          <= r_res_status;
                o_occupancy       <= OCC_W'(r_count);
            end
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/idxheap_ctrl.sv
// Controller of the indexed min-heap queue: sequences the clearing pass,
// the command checks and the sift loops. Depends on idxheap_pkg.
module idxheap_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    output logic                    o_valid,
    input  logic                    i_stall,
    input  idxheap_pkg::t_dp_status i_status_flags,
    output idxheap_pkg::t_dp_op     o_op
);
    import idxheap_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_DEC_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_stall = r_stall;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_stall     = r_stall;
        n_out_valid = r_out_valid && i_stall;
        o_op        = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_status_flags.clr_last) begin
                    n_state = S_IDLE;
                    n_stall = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_DECIDE;
                    n_stall = 1'b1;
                end
            end
            S_DECIDE: begin
                n_state = S_FIN;
                o_op    = OP_ERR;
                case (i_status_flags.cmd)
                    CMD_PUSH: begin
                        if (i_status_flags.push_ok) begin
                            o_op    = OP_PUSH_START;
                            n_state = S_UP_RD;
                        end
                    end
                    CMD_POP: begin
                        if (i_status_flags.nonempty) begin
                            o_op    = OP_POP_START;
                            n_state = i_status_flags.last_one ? S_FIN : S_DN_RD;
                        end
                    end
                    CMD_DEC: begin
                        if (i_status_flags.dec_ok) begin
                            o_op    = OP_DEC_RD;
                            n_state = S_DEC_CMP;
                        end
                    end
                    default: ;
                endcase
            end
            S_DEC_CMP: begin
                if (i_status_flags.dec_lower) begin
                    o_op    = OP_DEC_START;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_UP_RD: begin
                if (i_status_flags.slot_zero) begin
                    o_op    = OP_PLACE;
                    n_state = S_FIN;
                end else begin
                    o_op    = OP_UP_RD;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_status_flags.up_go) begin
                    o_op    = OP_UP_MOVE;
                    n_state = S_UP_RD;
                end else begin
                    o_op    = OP_PLACE;
                    n_state = S_FIN;
                end
            end
            S_DN_RD: begin
                o_op    = OP_DN_RD;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_status_flags.dn_go) begin
                    o_op    = OP_DN_MOVE;
                    n_state = S_DN_RD;
                end else begin
                    o_op    = OP_PLACE;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    o_op        = OP_OUT;
                    n_state     = S_IDLE;
                    n_stall     = 1'b0;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_stall     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stall     <= n_stall;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap queue with decrease-key.
// Joins idxheap_ctrl and idxheap_datapath; depends on idxheap_pkg.
//
// Each request on the input channel is one command: push a node with a key,
// pop the node with the smallest key, or lower the key of a queued node.
// Every request gives exactly one result: the popped node and key (zero
// unless a pop succeeded), a status code and the occupancy afterwards.
// Requests are taken one at a time; o_stall is high while one is at work.
// A request that fails a check holds the block only for the check and the
// result. A request that sifts walks L heap levels, where L is at most
// log2 of NODE_COUNT. Each level is one registered read of the heap memory
// and one compare and write, so the heap memory port sets the rate.
// Results sit in an output register, so the next request may be taken while
// a result waits under i_stall; the finished request after it waits in turn.
// After reset the membership table is cleared, one entry per cycle, which
// keeps o_stall high until all NODE_COUNT entries are cleared.
module indexed_min_heap_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [idxheap_pkg::CMD_W-1:0] i_command,
    input  logic [idxheap_pkg::ID_W-1:0]  i_node_id,
    input  logic [idxheap_pkg::PRI_W-1:0] i_priority_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [idxheap_pkg::ID_W-1:0]  o_popped_node,
    output logic [idxheap_pkg::PRI_W-1:0] o_popped_priority,
    output logic [idxheap_pkg::STS_W-1:0] o_status,
    output logic [idxheap_pkg::OCC_W-1:0] o_occupancy
);
    import idxheap_pkg::*;

    t_dp_op     dp_op;
    t_dp_status dp_flags;

    idxheap_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .i_status_flags (dp_flags),
        .o_op           (dp_op)
    );

    idxheap_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (dp_op),
        .o_status_flags    (dp_flags),
        .i_command         (i_command),
        .i_node_id         (i_node_id),
        .i_priority_req    (i_priority_req),
        .o_popped_node     (o_popped_node),
        .o_popped_priority (o_popped_priority),
        .o_status          (o_status),
        .o_occupancy       (o_occupancy)
    );

endmodule
